// ----- design/xbg_pkg.sv -----
// Package: shared constants and beat types for the xorshift byte generator.
`timescale 1ns / 1ps

package xbg_pkg;

  localparam int MAX_REQUEST_BYTES_DEF = 64;

  localparam logic [31:0] RESET_WORD = 32'h6d2b79f5;
  localparam logic [31:0] GOLDEN_MIX = 32'h9e3779b9;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_FILL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] seed_value;
    logic [31:0] time_value;
    logic [6:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rand_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic emit_last;
  } bk_status_t;

endpackage

// ----- design/xbg_fifo.sv -----
// Two-entry queue used between front, back and result ports.
`timescale 1ns / 1ps

module xbg_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- design/xbg_front.sv -----
// Front end: accepts items, saturates counts, drops empty fills, queues commands.
`timescale 1ns / 1ps

module xbg_front import xbg_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF,
  parameter int CW = $clog2(MAX_REQUEST_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  in_item_t      item,
  output logic          full,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output logic          cmd_fill,
  output logic [31:0]   cmd_value,
  output logic [CW-1:0] cmd_count
);

  localparam int BW = $bits(item.byte_count);
  localparam int WW = (CW > BW) ? CW : BW;
  localparam int QW = 1 + 32 + CW;

  logic [WW-1:0] cnt_ext;
  logic [WW-1:0] max_ext;
  logic [WW-1:0] sat;
  logic          is_fill;
  logic          keep;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  logic          q_empty;

  assign cnt_ext = WW'(item.byte_count);
  assign max_ext = WW'(MAX_REQUEST_BYTES);
  assign sat     = (cnt_ext > max_ext) ? max_ext : cnt_ext;
  assign is_fill = (item.opcode == OP_FILL);
  // a fill of zero bytes changes nothing, so it never reaches the back end
  assign keep    = !(is_fill && (sat == '0));
  assign q_in    = {is_fill, is_fill ? item.time_value : item.seed_value, sat[CW-1:0]};

  xbg_fifo #(.W(QW)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (push && keep),
    .wdata (q_in),
    .full  (full),
    .rd_en (cmd_pop),
    .rdata (q_out),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_fill  = q_out[QW-1];
  assign cmd_value = q_out[CW +: 32];
  assign cmd_count = q_out[CW-1:0];

endmodule

// ----- design/xbg_back.sv -----
// Back end: holds the generator word, applies seeds and emits fill bytes.
`timescale 1ns / 1ps

module xbg_back import xbg_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF,
  parameter int CW = $clog2(MAX_REQUEST_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  logic          cmd_fill,
  input  logic [31:0]   cmd_value,
  input  logic [CW-1:0] cmd_count,
  input  logic          res_full,
  output logic          res_push,
  output out_item_t     res_data,
  output bk_status_t    status
);

  logic          busy;
  logic [31:0]   gen_state;
  logic [31:0]   word;
  logic [31:0]   tval;
  logic [CW-1:0] remaining;
  logic [1:0]    idx;

  logic [31:0] x0;
  logic [31:0] x1;
  logic [31:0] xa;
  logic [31:0] xb;
  logic [31:0] fresh;
  logic [31:0] mixed;
  logic        step;
  logic        at_last;

  assign x0    = gen_state ^ tval;
  assign x1    = (x0 == 32'd0) ? 32'd1 : x0;
  assign xa    = x1 ^ (x1 << 13);
  assign xb    = xa ^ (xa >> 17);
  assign fresh = xb ^ (xb << 5);
  assign mixed = gen_state ^ (cmd_value + GOLDEN_MIX + (gen_state << 6) + (gen_state >> 2));

  assign step    = busy && !res_full;
  assign at_last = (remaining == CW'(1));
  assign cmd_pop = !busy && cmd_valid;

  assign res_push           = step;
  assign res_data.rand_byte = (idx == 2'd0) ? fresh[7:0] : word[7:0];
  assign res_data.last_byte = at_last;

  assign status.busy      = busy;
  assign status.emit      = step;
  assign status.emit_last = step && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      gen_state <= RESET_WORD;
    end else begin
      priority if (cmd_pop) begin
        if (cmd_fill) begin
          busy      <= 1'b1;
          tval      <= cmd_value;
          remaining <= cmd_count;
          idx       <= 2'd0;
        end else begin
          gen_state <= mixed;
        end
      end else if (step) begin
        idx       <= idx + 2'd1;
        remaining <= remaining - CW'(1);
        if (idx == 2'd0) begin
          gen_state <= fresh;
          word      <= fresh >> 8;
        end else begin
          word <= word >> 8;
        end
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/xorshift_byte_generator.sv -----
// Top level: xorshift32 byte source with queued commands and queued result beats.
// Seed item: mixed into the generator word when the back end takes it from the command queue.
// Fill item of N bytes: the single byte sequencer takes the command, then emits one byte
// beat per cycle while the result queue is not full, N beats in all.
// Two-entry queues sit before and after the back end, so either side may stall.
// Reset (rst, synchronous): queues empty, sequencer idle, generator word 0x6d2b79f5.
`timescale 1ns / 1ps

module xorshift_byte_generator import xbg_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  input  logic      pop,
  output out_item_t result,
  output logic      empty
);

  localparam int CW = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int RW = $bits(out_item_t);

  logic          cmd_valid;
  logic          cmd_pop;
  logic          cmd_fill;
  logic [31:0]   cmd_value;
  logic [CW-1:0] cmd_count;
  logic          res_full;
  logic          res_push;
  out_item_t     res_data;
  bk_status_t    status;
  logic [RW-1:0] res_out;

  xbg_front #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES), .CW(CW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_fill  (cmd_fill),
    .cmd_value (cmd_value),
    .cmd_count (cmd_count)
  );

  xbg_back #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES), .CW(CW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_fill  (cmd_fill),
    .cmd_value (cmd_value),
    .cmd_count (cmd_count),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .status    (status)
  );

  xbg_fifo #(.W(RW)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (res_push),
    .wdata (res_data),
    .full  (res_full),
    .rd_en (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign result = out_item_t'(res_out);

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("beat pushed into full result queue");

  a_last_ends_fill: assert property (@(posedge clk) disable iff (rst)
    status.emit_last |=> !status.busy) else $error("sequencer busy after last beat");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !cmd_pop) else $error("command taken while fill in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !status.busy)) else $error("not idle after reset");
`endif

endmodule
